>>> rtl/lobm_pkg.sv
`default_nettype none
package lobm_pkg;

	localparam int DEF_BOOK_DEPTH  = 16;
	localparam int DEF_NUM_SYMBOLS = 8;

	localparam logic CMD_SUBMIT  = 1'b0;
	localparam logic CMD_CANCEL  = 1'b1;
	localparam logic SIDE_BUY    = 1'b0;
	localparam logic SIDE_SELL   = 1'b1;
	localparam logic TYPE_LIMIT  = 1'b0;
	localparam logic TYPE_MARKET = 1'b1;
	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MATCH_WAIT,
		ST_MATCH_DECIDE,
		ST_AFTER_FILL,
		ST_FREE_WAIT,
		ST_REST,
		ST_CANCEL_WAIT,
		ST_STATUS_GO,
		ST_BID_WAIT,
		ST_ASK_WAIT
	} state_t;

	typedef enum logic [2:0] {
		SCAN_OPP,
		SCAN_BID,
		SCAN_ASK,
		SCAN_FREE,
		SCAN_CANCEL
	} scan_kind_t;

	typedef struct packed {
		logic       load;
		logic       scan_go;
		scan_kind_t scan_kind;
		logic       fill;
		logic       rest;
		logic       full;
		logic       cancel_apply;
		logic       cap_bid;
		logic       emit_status;
	} cmd_t;

	typedef struct packed {
		logic scan_busy;
		logic found;
		logic match_ok;
		logic is_cancel;
		logic is_market;
		logic rem_zero;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/lobm_ctrl.sv
`default_nettype none
module lobm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire lobm_pkg::stat_t st,
	output lobm_pkg::cmd_t     cmd
);

	lobm_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lobm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lobm_pkg::ST_IDLE: begin
				if (start) state_nx = lobm_pkg::ST_DISPATCH;
			end
			lobm_pkg::ST_DISPATCH: begin
				if (st.is_cancel) state_nx = lobm_pkg::ST_CANCEL_WAIT;
				else if (st.rem_zero) state_nx = lobm_pkg::ST_STATUS_GO;
				else state_nx = lobm_pkg::ST_MATCH_WAIT;
			end
			lobm_pkg::ST_MATCH_WAIT: begin
				if (!st.scan_busy) state_nx = lobm_pkg::ST_MATCH_DECIDE;
			end
			lobm_pkg::ST_MATCH_DECIDE: begin
				if (st.match_ok) state_nx = lobm_pkg::ST_AFTER_FILL;
				else if (st.is_market) state_nx = lobm_pkg::ST_STATUS_GO;
				else state_nx = lobm_pkg::ST_FREE_WAIT;
			end
			lobm_pkg::ST_AFTER_FILL: begin
				if (st.rem_zero) state_nx = lobm_pkg::ST_STATUS_GO;
				else state_nx = lobm_pkg::ST_MATCH_WAIT;
			end
			lobm_pkg::ST_FREE_WAIT: begin
				if (!st.scan_busy) state_nx = lobm_pkg::ST_REST;
			end
			lobm_pkg::ST_REST:        state_nx = lobm_pkg::ST_STATUS_GO;
			lobm_pkg::ST_CANCEL_WAIT: begin
				if (!st.scan_busy) state_nx = lobm_pkg::ST_STATUS_GO;
			end
			lobm_pkg::ST_STATUS_GO:   state_nx = lobm_pkg::ST_BID_WAIT;
			lobm_pkg::ST_BID_WAIT: begin
				if (!st.scan_busy) state_nx = lobm_pkg::ST_ASK_WAIT;
			end
			lobm_pkg::ST_ASK_WAIT: begin
				if (!st.scan_busy) state_nx = lobm_pkg::ST_IDLE;
			end
			default: state_nx = lobm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.scan_kind = lobm_pkg::SCAN_BID;
		busy = (state_q != lobm_pkg::ST_IDLE);
		unique case (state_q)
			lobm_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			lobm_pkg::ST_DISPATCH: begin
				if (st.is_cancel) begin
					cmd.scan_go   = 1'b1;
					cmd.scan_kind = lobm_pkg::SCAN_CANCEL;
				end else if (!st.rem_zero) begin
					cmd.scan_go   = 1'b1;
					cmd.scan_kind = lobm_pkg::SCAN_OPP;
				end
			end
			lobm_pkg::ST_MATCH_DECIDE: begin
				if (st.match_ok) begin
					cmd.fill = 1'b1;
				end else if (!st.is_market) begin
					cmd.scan_go   = 1'b1;
					cmd.scan_kind = lobm_pkg::SCAN_FREE;
				end
			end
			lobm_pkg::ST_AFTER_FILL: begin
				if (!st.rem_zero) begin
					cmd.scan_go   = 1'b1;
					cmd.scan_kind = lobm_pkg::SCAN_OPP;
				end
			end
			lobm_pkg::ST_REST: begin
				cmd.rest = st.found;
				cmd.full = !st.found;
			end
			lobm_pkg::ST_CANCEL_WAIT: begin
				cmd.cancel_apply = !st.scan_busy;
			end
			lobm_pkg::ST_STATUS_GO: begin
				cmd.scan_go   = 1'b1;
				cmd.scan_kind = lobm_pkg::SCAN_BID;
			end
			lobm_pkg::ST_BID_WAIT: begin
				if (!st.scan_busy) begin
					cmd.cap_bid   = 1'b1;
					cmd.scan_go   = 1'b1;
					cmd.scan_kind = lobm_pkg::SCAN_ASK;
				end
			end
			lobm_pkg::ST_ASK_WAIT: begin
				cmd.emit_status = !st.scan_busy;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/lobm_datapath.sv
`default_nettype none
module lobm_datapath #(
	parameter int BOOK_DEPTH  = lobm_pkg::DEF_BOOK_DEPTH,
	parameter int NUM_SYMBOLS = lobm_pkg::DEF_NUM_SYMBOLS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lobm_pkg::cmd_t cmd,
	output lobm_pkg::stat_t    st,
	input  wire logic          command,
	input  wire logic [63:0]   ord_id,
	input  wire logic [2:0]    symbol,
	input  wire logic          side,
	input  wire logic          order_type,
	input  wire logic [31:0]   price,
	input  wire logic [31:0]   quantity,
	output logic               valid,
	output logic               kind,
	output logic [63:0]        buy_id,
	output logic [63:0]        sell_id,
	output logic [2:0]         trade_symbol,
	output logic [31:0]        trade_price,
	output logic [31:0]        amount,
	output logic [1:0]         status,
	output logic [31:0]        best_bid,
	output logic               bid_valid,
	output logic [31:0]        best_ask,
	output logic               ask_valid,
	output logic               last
);

	localparam int SLOTS = NUM_SYMBOLS * 2 * BOOK_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int SYMW  = ($clog2(NUM_SYMBOLS) > 3) ? $clog2(NUM_SYMBOLS) : 3;
	localparam int PW    = $clog2(2 * BOOK_DEPTH);

	function automatic logic [SYMW-1:0] sym_reduce(input logic [2:0] s);
		logic [SYMW-1:0] v;
		v = SYMW'(s);
		for (int i = 0; i < 8; i++) begin
			if (v >= SYMW'(NUM_SYMBOLS)) v = v - SYMW'(NUM_SYMBOLS);
		end
		return v;
	endfunction

	logic [63:0] mem_id    [SLOTS];
	logic [31:0] mem_price [SLOTS];
	logic [31:0] mem_rem   [SLOTS];
	logic [31:0] mem_arr   [SLOTS];
	logic [SLOTS-1:0] valid_q;

	logic            cmd_q, side_q, market_q;
	logic [63:0]     id_q;
	logic [SYMW-1:0] sym_q;
	logic [31:0]     price_q, rem_q, amount_q, arr_q, bb_q;
	logic [1:0]      stat_q;
	logic            bv_q;

	lobm_pkg::scan_kind_t kind_q;
	logic            scan_side_q, issue_q;
	logic [AW-1:0]   addr_q, cnt_q, last_cnt_q;
	logic [PW-1:0]   pos_q;
	logic [SYMW-1:0] scan_sym_q;

	logic            vld_s1;
	logic [AW-1:0]   addr_s1;
	logic [SYMW-1:0] sym_s1;
	logic [63:0]     rd_id_s1;
	logic [31:0]     rd_price_s1, rd_rem_s1, rd_arr_s1;

	logic            found_q;
	logic [AW-1:0]   best_addr_q;
	logic [31:0]     best_price_q, best_age_q, best_rem_q;
	logic [63:0]     best_id_q;
	logic [SYMW-1:0] best_sym_q;

	logic        ent_v, better;
	logic [31:0] age, fill, new_rem;
	logic        scan_side_nx;
	logic [AW-1:0] base;

	always_comb begin
		unique case (cmd.scan_kind)
			lobm_pkg::SCAN_OPP:  scan_side_nx = ~side_q;
			lobm_pkg::SCAN_BID:  scan_side_nx = lobm_pkg::SIDE_BUY;
			lobm_pkg::SCAN_ASK:  scan_side_nx = lobm_pkg::SIDE_SELL;
			default:             scan_side_nx = side_q;
		endcase
		base = AW'({sym_q, scan_side_nx} * BOOK_DEPTH);
	end

	always_comb begin
		ent_v = valid_q[addr_s1];
		age   = arr_q - rd_arr_s1;
		unique case (kind_q)
			lobm_pkg::SCAN_FREE:   better = !ent_v && !found_q;
			lobm_pkg::SCAN_CANCEL: better = ent_v && (rd_id_s1 == id_q) &&
			                                (!found_q || (age < best_age_q));
			default: begin
				if (!found_q) better = ent_v;
				else if (rd_price_s1 == best_price_q) better = ent_v && (age > best_age_q);
				else if (scan_side_q == lobm_pkg::SIDE_SELL)
					better = ent_v && (rd_price_s1 < best_price_q);
				else
					better = ent_v && (rd_price_s1 > best_price_q);
			end
		endcase
		fill    = (rem_q < best_rem_q) ? rem_q : best_rem_q;
		new_rem = best_rem_q - fill;
	end

	always_comb begin
		st.scan_busy = issue_q | vld_s1;
		st.found     = found_q;
		st.is_cancel = (cmd_q == lobm_pkg::CMD_CANCEL);
		st.is_market = market_q;
		st.rem_zero  = (rem_q == 32'd0);
		if (!found_q) st.match_ok = 1'b0;
		else if (market_q) st.match_ok = 1'b1;
		else if (side_q == lobm_pkg::SIDE_BUY) st.match_ok = (price_q >= best_price_q);
		else st.match_ok = (price_q <= best_price_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			if (cmd.scan_go) issue_q <= 1'b1;
			else if (issue_q && cnt_q == last_cnt_q) issue_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= addr_q;
		sym_s1      <= scan_sym_q;
		rd_id_s1    <= mem_id[addr_q];
		rd_price_s1 <= mem_price[addr_q];
		rd_rem_s1   <= mem_rem[addr_q];
		rd_arr_s1   <= mem_arr[addr_q];
		if (cmd.scan_go) begin
			kind_q      <= cmd.scan_kind;
			scan_side_q <= scan_side_nx;
			cnt_q       <= '0;
			pos_q       <= '0;
			scan_sym_q  <= '0;
			if (cmd.scan_kind == lobm_pkg::SCAN_CANCEL) begin
				addr_q     <= '0;
				last_cnt_q <= AW'(SLOTS - 1);
			end else begin
				addr_q     <= base;
				last_cnt_q <= AW'(BOOK_DEPTH - 1);
			end
		end else if (issue_q) begin
			addr_q <= addr_q + AW'(1);
			cnt_q  <= cnt_q + AW'(1);
			if (pos_q == PW'(2 * BOOK_DEPTH - 1)) begin
				pos_q      <= '0;
				scan_sym_q <= scan_sym_q + SYMW'(1);
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_go) begin
			found_q <= 1'b0;
		end else if (vld_s1 && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && better && !cmd.scan_go) begin
			best_addr_q  <= addr_s1;
			best_price_q <= rd_price_s1;
			best_age_q   <= age;
			best_rem_q   <= rd_rem_s1;
			best_id_q    <= rd_id_s1;
			best_sym_q   <= sym_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill) mem_rem[best_addr_q] <= new_rem;
		if (cmd.rest) begin
			mem_id[best_addr_q]    <= id_q;
			mem_price[best_addr_q] <= price_q;
			mem_rem[best_addr_q]   <= rem_q;
			mem_arr[best_addr_q]   <= arr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			arr_q   <= '0;
		end else begin
			if (cmd.fill && new_rem == 32'd0) valid_q[best_addr_q] <= 1'b0;
			if (cmd.cancel_apply && found_q) valid_q[best_addr_q] <= 1'b0;
			if (cmd.rest) begin
				valid_q[best_addr_q] <= 1'b1;
				arr_q <= arr_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			id_q     <= ord_id;
			sym_q    <= sym_reduce(symbol);
			side_q   <= side;
			market_q <= (order_type == lobm_pkg::TYPE_MARKET);
			price_q  <= price;
			rem_q    <= quantity;
			amount_q <= '0;
			stat_q   <= lobm_pkg::STAT_DONE;
		end
		if (cmd.fill) rem_q <= rem_q - fill;
		if (cmd.rest) amount_q <= rem_q;
		if (cmd.full) stat_q <= lobm_pkg::STAT_FULL;
		if (cmd.cancel_apply) begin
			if (found_q) begin
				amount_q <= best_rem_q;
				sym_q    <= best_sym_q;
			end else begin
				stat_q <= lobm_pkg::STAT_NOT_FOUND;
			end
		end
		if (cmd.cap_bid) begin
			bb_q <= found_q ? best_price_q : 32'd0;
			bv_q <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else begin
			valid <= cmd.fill | cmd.emit_status;
		end
	end

	always_ff @(posedge clk) begin
		trade_symbol <= sym_q[2:0];
		if (cmd.fill) begin
			kind        <= lobm_pkg::KIND_TRADE;
			buy_id      <= (side_q == lobm_pkg::SIDE_BUY) ? id_q : best_id_q;
			sell_id     <= (side_q == lobm_pkg::SIDE_SELL) ? id_q : best_id_q;
			trade_price <= best_price_q;
			amount      <= fill;
			status      <= lobm_pkg::STAT_DONE;
			best_bid    <= '0;
			bid_valid   <= 1'b0;
			best_ask    <= '0;
			ask_valid   <= 1'b0;
			last        <= 1'b0;
		end else begin
			kind        <= lobm_pkg::KIND_STATUS;
			buy_id      <= '0;
			sell_id     <= '0;
			trade_price <= '0;
			amount      <= amount_q;
			status      <= stat_q;
			best_bid    <= bb_q;
			bid_valid   <= bv_q;
			best_ask    <= found_q ? best_price_q : 32'd0;
			ask_valid   <= found_q;
			last        <= 1'b1;
		end
	end

	a_trade_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == lobm_pkg::KIND_TRADE) |-> amount != 32'd0)
		else $error("trade with zero amount");
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == (kind == lobm_pkg::KIND_STATUS)))
		else $error("last mark disagrees with item kind");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_go |-> !(issue_q || vld_s1))
		else $error("scan started while one is running");
	a_fill_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill || cmd.rest) |-> found_q && !(issue_q || vld_s1))
		else $error("entry update without a located slot");

endmodule
`default_nettype wire

>>> rtl/limit_order_book_matcher_top.sv
`default_nettype none
// Price-time priority order book matcher. Raise start with a command while busy is low;
// busy then stays high until the command's final status item has been produced. Results
// appear for one cycle each with valid high and cannot be held off: capture every valid
// cycle. A submit scans the opposite side of its symbol for the best price before each
// fill, and a limit remainder then scans its own side for a free slot; a zero quantity
// skips the matching. A cancel scans every slot for the id. Each command ends with a scan
// of the bid side and then of the ask side for the status item, which appears with valid
// high in the same cycle that busy first reads low. Busy time is set by the entry memory,
// which the block scans one slot per cycle for each of these searches.
module limit_order_book_matcher_top #(
	parameter int BOOK_DEPTH  = lobm_pkg::DEF_BOOK_DEPTH,
	parameter int NUM_SYMBOLS = lobm_pkg::DEF_NUM_SYMBOLS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        command,
	input  wire logic [63:0] ord_id,
	input  wire logic [2:0]  symbol,
	input  wire logic        side,
	input  wire logic        order_type,
	input  wire logic [31:0] price,
	input  wire logic [31:0] quantity,
	output logic             valid,
	output logic             kind,
	output logic [63:0]      buy_id,
	output logic [63:0]      sell_id,
	output logic [2:0]       trade_symbol,
	output logic [31:0]      trade_price,
	output logic [31:0]      amount,
	output logic [1:0]       status,
	output logic [31:0]      best_bid,
	output logic             bid_valid,
	output logic [31:0]      best_ask,
	output logic             ask_valid,
	output logic             last
);

	lobm_pkg::cmd_t  cmd;
	lobm_pkg::stat_t st;

	lobm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	lobm_datapath #(
		.BOOK_DEPTH  (BOOK_DEPTH),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.command      (command),
		.ord_id       (ord_id),
		.symbol       (symbol),
		.side         (side),
		.order_type   (order_type),
		.price        (price),
		.quantity     (quantity),
		.valid        (valid),
		.kind         (kind),
		.buy_id       (buy_id),
		.sell_id      (sell_id),
		.trade_symbol (trade_symbol),
		.trade_price  (trade_price),
		.amount       (amount),
		.status       (status),
		.best_bid     (best_bid),
		.bid_valid    (bid_valid),
		.best_ask     (best_ask),
		.ask_valid    (ask_valid),
		.last         (last)
	);

endmodule
`default_nettype wire

>>> tb/sv/limit_order_book_matcher_top_tb.sv
`default_nettype none
module limit_order_book_matcher_top_tb;

	localparam int DEPTH = lobm_pkg::DEF_BOOK_DEPTH;
	localparam int NSYM  = lobm_pkg::DEF_NUM_SYMBOLS;
	localparam int SLOTS = NSYM * 2 * DEPTH;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic        command;
		logic [63:0] ord_id;
		logic [2:0]  symbol;
		logic        side;
		logic        order_type;
		logic [31:0] price;
		logic [31:0] quantity;
	} order_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] buy_id;
		logic [63:0] sell_id;
		logic [2:0]  trade_symbol;
		logic [31:0] trade_price;
		logic [31:0] amount;
		logic [1:0]  status;
		logic [31:0] best_bid;
		logic        bid_valid;
		logic [31:0] best_ask;
		logic        ask_valid;
		logic        last;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic command = 1'b0;
	logic [63:0] ord_id = '0;
	logic [2:0] symbol = '0;
	logic side = 1'b0;
	logic order_type = 1'b0;
	logic [31:0] price = '0;
	logic [31:0] quantity = '0;
	logic valid, kind, bid_valid, ask_valid, last;
	logic [63:0] buy_id, sell_id;
	logic [2:0] trade_symbol;
	logic [31:0] trade_price, amount, best_bid, best_ask;
	logic [1:0] status;

	limit_order_book_matcher_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .ord_id(ord_id), .symbol(symbol), .side(side),
		.order_type(order_type), .price(price), .quantity(quantity),
		.valid(valid), .kind(kind), .buy_id(buy_id), .sell_id(sell_id),
		.trade_symbol(trade_symbol), .trade_price(trade_price), .amount(amount),
		.status(status), .best_bid(best_bid), .bid_valid(bid_valid),
		.best_ask(best_ask), .ask_valid(ask_valid), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic        bk_valid [SLOTS];
	logic [63:0] bk_id    [SLOTS];
	logic [31:0] bk_price [SLOTS];
	logic [31:0] bk_rem   [SLOTS];
	logic [31:0] bk_arr   [SLOTS];
	logic [31:0] arrival_cnt;

	order_t  pending_orders[$];
	report_t expected_reports[$];
	logic [63:0] live_ids[$];
	int sender_idle_pct = 20;
	int mismatches = 0;
	int watchdog = 0;

	function automatic int best_of(int sym, logic sd);
		int base, found, k;
		logic [31:0] bp, bage, age;
		logic better;
		base = (sym * 2 + sd) * DEPTH;
		found = -1;
		bp = '0;
		bage = '0;
		for (k = 0; k < DEPTH; k++) begin
			if (bk_valid[base + k]) begin
				age = arrival_cnt - bk_arr[base + k];
				if (found < 0) better = 1'b1;
				else if (bk_price[base + k] == bp) better = age > bage;
				else if (sd == lobm_pkg::SIDE_BUY) better = bk_price[base + k] > bp;
				else better = bk_price[base + k] < bp;
				if (better) begin
					found = base + k;
					bp = bk_price[base + k];
					bage = age;
				end
			end
		end
		return found;
	endfunction

	task automatic match_order(input order_t o);
		int sym, s, k, freeslot;
		logic [31:0] rem, fill, amt, fage, age;
		logic [1:0] st;
		report_t r;
		sym = int'(o.symbol) % NSYM;
		amt = '0;
		st = lobm_pkg::STAT_DONE;
		if (o.command != lobm_pkg::CMD_CANCEL) begin
			rem = o.quantity;
			while (rem > 0) begin
				s = best_of(sym, ~o.side);
				if (s < 0) break;
				if (o.order_type != lobm_pkg::TYPE_MARKET) begin
					if (o.side == lobm_pkg::SIDE_BUY && o.price < bk_price[s]) break;
					if (o.side == lobm_pkg::SIDE_SELL && o.price > bk_price[s]) break;
				end
				fill = rem < bk_rem[s] ? rem : bk_rem[s];
				r = '0;
				r.kind = lobm_pkg::KIND_TRADE;
				r.buy_id = o.side == lobm_pkg::SIDE_BUY ? o.ord_id : bk_id[s];
				r.sell_id = o.side == lobm_pkg::SIDE_SELL ? o.ord_id : bk_id[s];
				r.trade_symbol = sym[2:0];
				r.trade_price = bk_price[s];
				r.amount = fill;
				expected_reports.push_back(r);
				bk_rem[s] -= fill;
				if (bk_rem[s] == 0) bk_valid[s] = 1'b0;
				rem -= fill;
			end
			if (rem > 0 && o.order_type != lobm_pkg::TYPE_MARKET) begin
				freeslot = -1;
				for (k = 0; k < DEPTH; k++)
					if (freeslot < 0 && !bk_valid[(sym * 2 + o.side) * DEPTH + k])
						freeslot = (sym * 2 + o.side) * DEPTH + k;
				if (freeslot < 0) st = lobm_pkg::STAT_FULL;
				else begin
					bk_valid[freeslot] = 1'b1;
					bk_id[freeslot] = o.ord_id;
					bk_price[freeslot] = o.price;
					bk_rem[freeslot] = rem;
					bk_arr[freeslot] = arrival_cnt;
					arrival_cnt++;
					amt = rem;
					live_ids.push_back(o.ord_id);
				end
			end
		end else begin
			s = -1;
			fage = '0;
			for (k = 0; k < SLOTS; k++) begin
				if (bk_valid[k] && bk_id[k] == o.ord_id) begin
					age = arrival_cnt - bk_arr[k];
					if (s < 0 || age < fage) begin
						s = k;
						fage = age;
					end
				end
			end
			if (s < 0) st = lobm_pkg::STAT_NOT_FOUND;
			else begin
				amt = bk_rem[s];
				bk_valid[s] = 1'b0;
				sym = s / (2 * DEPTH);
			end
		end
		r = '0;
		r.kind = lobm_pkg::KIND_STATUS;
		r.trade_symbol = sym[2:0];
		r.amount = amt;
		r.status = st;
		s = best_of(sym, lobm_pkg::SIDE_BUY);
		if (s >= 0) begin
			r.best_bid = bk_price[s];
			r.bid_valid = 1'b1;
		end
		s = best_of(sym, lobm_pkg::SIDE_SELL);
		if (s >= 0) begin
			r.best_ask = bk_price[s];
			r.ask_valid = 1'b1;
		end
		r.last = 1'b1;
		expected_reports.push_back(r);
	endtask

	function automatic order_t mk(logic cmd, logic [63:0] id, logic [2:0] sym, logic sd,
			logic ot, logic [31:0] p, logic [31:0] q);
		order_t o;
		o.command = cmd;
		o.ord_id = id;
		o.symbol = sym;
		o.side = sd;
		o.order_type = ot;
		o.price = p;
		o.quantity = q;
		return o;
	endfunction

	function automatic order_t random_order();
		order_t o;
		int pick;
		pick = $urandom_range(0, 99);
		o.command = lobm_pkg::CMD_SUBMIT;
		o.ord_id = {$urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd0}
			| 64'($urandom_range(1, 60));
		o.symbol = $urandom_range(0, 3) == 0 ? 3'($urandom) : 3'($urandom_range(0, 1));
		o.side = 1'($urandom);
		o.order_type = ($urandom_range(0, 7) == 0) ? lobm_pkg::TYPE_MARKET
			: lobm_pkg::TYPE_LIMIT;
		o.price = $urandom_range(0, 15) == 0 ? $urandom : 32'd100 + $urandom_range(0, 8);
		o.quantity = $urandom_range(0, 15) == 0 ? $urandom : 32'($urandom_range(0, 40));
		if (pick < 20) begin
			o.command = lobm_pkg::CMD_CANCEL;
			if (live_ids.size() > 0 && pick < 15)
				o.ord_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
			o.price = $urandom;
			o.quantity = $urandom;
		end
		return o;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				bk_valid[i] = 1'b0;
				bk_id[i] = '0;
				bk_price[i] = '0;
				bk_rem[i] = '0;
				bk_arr[i] = '0;
			end
			arrival_cnt = '0;
		end else begin
			if (start && !busy)
				match_order(pending_orders.pop_front());
			if (pending_orders.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				start <= 1'b1;
				command <= pending_orders[0].command;
				ord_id <= pending_orders[0].ord_id;
				symbol <= pending_orders[0].symbol;
				side <= pending_orders[0].side;
				order_type <= pending_orders[0].order_type;
				price <= pending_orders[0].price;
				quantity <= pending_orders[0].quantity;
			end else if (start && !busy)
				start <= 1'b0;
			else if (!start || pending_orders.size() == 0)
				start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		report_t got, want;
		if (arst_n && valid) begin
			got = {kind, buy_id, sell_id, trade_symbol, trade_price, amount, status,
				best_bid, bid_valid, best_ask, ask_valid, last};
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected report %h", got);
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd1, 3'd0, lobm_pkg::SIDE_SELL,
			lobm_pkg::TYPE_LIMIT, 32'd100, 32'd10));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd2, 3'd0, lobm_pkg::SIDE_SELL,
			lobm_pkg::TYPE_LIMIT, 32'd100, 32'd5));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd3, 3'd0, lobm_pkg::SIDE_SELL,
			lobm_pkg::TYPE_LIMIT, 32'd99, 32'd7));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd4, 3'd0, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_LIMIT, 32'd98, 32'd3));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd5, 3'd0, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_LIMIT, 32'd100, 32'd20));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd6, 3'd0, lobm_pkg::SIDE_SELL,
			lobm_pkg::TYPE_MARKET, 32'hFFFFFFFF, 32'd50));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd7, 3'd0, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_LIMIT, 32'd10, 32'd0));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'hFFFFFFFFFFFFFFFF, 3'd7,
			lobm_pkg::SIDE_BUY, lobm_pkg::TYPE_LIMIT, 32'hFFFFFFFF, 32'hFFFFFFFF));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd8, 3'd7, lobm_pkg::SIDE_SELL,
			lobm_pkg::TYPE_LIMIT, 32'd0, 32'hFFFFFFFF));
		pending_orders.push_back(mk(lobm_pkg::CMD_CANCEL, 64'd8, 3'd2, lobm_pkg::SIDE_SELL,
			lobm_pkg::TYPE_MARKET, 32'hFFFFFFFF, 32'hFFFFFFFF));
		pending_orders.push_back(mk(lobm_pkg::CMD_CANCEL, 64'd12345, 3'd5,
			lobm_pkg::SIDE_BUY, lobm_pkg::TYPE_LIMIT, 32'd0, 32'd0));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd9, 3'd3, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_LIMIT, 32'd50, 32'd1));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd9, 3'd3, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_LIMIT, 32'd51, 32'd2));
		pending_orders.push_back(mk(lobm_pkg::CMD_CANCEL, 64'd9, 3'd0, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_LIMIT, 32'd0, 32'd0));
		for (n = 0; n < DEPTH + 1; n++)
			pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd100 + n, 3'd4,
				lobm_pkg::SIDE_SELL, lobm_pkg::TYPE_LIMIT, 32'd200 + n, 32'd1));
		pending_orders.push_back(mk(lobm_pkg::CMD_SUBMIT, 64'd200, 3'd4, lobm_pkg::SIDE_BUY,
			lobm_pkg::TYPE_MARKET, 32'd0, 32'd20));
		for (n = 0; n < 88; n++) begin
			if (n == 28) begin
				wait (pending_orders.size() == 0);
				sender_idle_pct = 68;
			end
			if (n == 58) begin
				wait (pending_orders.size() == 0);
				sender_idle_pct = 0;
			end
			pending_orders.push_back(random_order());
		end
		wait (pending_orders.size() == 0 && !start);
		wait (expected_reports.size() == 0);
		repeat (DEPTH * 4 + 20) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("[limit_order_book_matcher_top] OK");
		else
			$display("[limit_order_book_matcher_top] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || valid)
				watchdog <= 0;
			else
				watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("[limit_order_book_matcher_top] ERROR");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
